// File: rtl/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Result codes, the decoded-job record passed from the parser to the output
// sequencer, and small decode and encode functions.
// ---------------------------------------------------------------------------
package jsu_pkg;

  // Result status codes.
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_CTRL      = 4'd1;
  localparam logic [3:0] ERR_TRUNC_ESC = 4'd2;
  localparam logic [3:0] ERR_TRUNC_U   = 4'd3;
  localparam logic [3:0] ERR_BAD_U     = 4'd4;
  localparam logic [3:0] ERR_UNPAIRED  = 4'd5;
  localparam logic [3:0] ERR_BAD_LOW   = 4'd6;
  localparam logic [3:0] ERR_BAD_ESC   = 4'd7;
  localparam logic [3:0] ERR_UNTERM    = 4'd8;

  // One decoded job: one to four result beats. bytes[0] goes out first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic [1:0]      status;
    logic [3:0]      err;
  } job_t;

  // Returns {invalid, value}; invalid is set when c is not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b0, c[3:0] + 4'd9};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

  function automatic job_t byte_job(input logic [7:0] c);
    job_t j;
    j          = '0;
    j.bytes[0] = c;
    j.status   = ST_DATA;
    j.err      = ERR_NONE;
    return j;
  endfunction

  function automatic job_t status_job(input logic [1:0] st, input logic [3:0] err);
    job_t j;
    j        = '0;
    j.status = st;
    j.err    = err;
    return j;
  endfunction

  // UTF-8 encoding of a code point up to 21 bits.
  function automatic job_t utf8_job(input logic [20:0] cp);
    job_t j;
    j        = '0;
    j.status = ST_DATA;
    j.err    = ERR_NONE;
    if (cp < 21'h80) begin
      j.bytes[0] = {1'b0, cp[6:0]};
      j.last_idx = 2'd0;
    end else if (cp < 21'h800) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.last_idx = 2'd1;
    end else if (cp < 21'h10000) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.last_idx = 2'd2;
    end else begin
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.last_idx = 2'd3;
    end
    return j;
  endfunction

endpackage

// File: rtl/jsu_front.sv
// ---------------------------------------------------------------------------
// jsu_front: input parser
// Accepts one input beat per cycle while the job queue has room, tracks the string and
// escape state, and turns every beat that causes results into one job for the output side.
// ---------------------------------------------------------------------------
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          func_i,
  input  logic [7:0]    in_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output jsu_pkg::job_t job_o
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_BODY  = 3'd1;
  localparam logic [2:0] MODE_ESC   = 3'd2;
  localparam logic [2:0] MODE_HEX   = 3'd3;
  localparam logic [2:0] MODE_PAIR  = 3'd4;
  localparam logic [2:0] MODE_DRAIN = 3'd5;

  logic [2:0]  mode_q, mode_d;
  logic [15:0] high_q, high_d;
  logic [15:0] low_q, low_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        bad_digit_q, bad_digit_d;
  logic        bad_prefix_q, bad_prefix_d;

  logic        accept;
  logic        emit;
  logic [4:0]  nib;
  logic [3:0]  nib_val;
  logic [15:0] high_new;
  logic [15:0] low_new;
  logic        bad_any;
  logic [20:0] pair_cp;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && emit;

  assign nib      = jsu_pkg::hex_nibble(in_byte_i);
  assign nib_val  = nib[4] ? 4'd0 : nib[3:0];
  assign high_new = {high_q[11:0], nib_val};
  assign low_new  = {low_q[11:0], nib_val};
  assign bad_any  = bad_digit_q || nib[4];
  // Surrogate pair: 0x10000 + (high - 0xD800) << 10 + (low - 0xDC00).
  assign pair_cp  = 21'h10000 + {1'b0, high_q[9:0], low_new[9:0]};

  always_comb begin
    mode_d       = mode_q;
    high_d       = high_q;
    low_d        = low_q;
    cnt_d        = cnt_q;
    bad_digit_d  = bad_digit_q;
    bad_prefix_d = bad_prefix_q;
    emit         = 1'b0;
    job_o        = '0;

    if (func_i) begin
      case (mode_q)
        MODE_BODY: begin
          emit  = 1'b1;
          job_o = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_UNTERM);
        end
        MODE_ESC: begin
          emit  = 1'b1;
          job_o = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_TRUNC_ESC);
        end
        MODE_HEX: begin
          emit  = 1'b1;
          job_o = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_TRUNC_U);
        end
        MODE_PAIR: begin
          emit  = 1'b1;
          job_o = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_UNPAIRED);
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      mode_d       = MODE_IDLE;
      high_d       = '0;
      low_d        = '0;
      cnt_d        = '0;
      bad_digit_d  = 1'b0;
      bad_prefix_d = 1'b0;
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          mode_d = MODE_BODY;
        end
        MODE_BODY: begin
          emit = 1'b1;
          if (in_byte_i == 8'h22) begin
            job_o        = jsu_pkg::status_job(jsu_pkg::ST_CLOSE, jsu_pkg::ERR_NONE);
            mode_d       = MODE_IDLE;
            high_d       = '0;
            low_d        = '0;
            cnt_d        = '0;
            bad_digit_d  = 1'b0;
            bad_prefix_d = 1'b0;
          end else if (in_byte_i < 8'h20) begin
            job_o  = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_CTRL);
            mode_d = MODE_DRAIN;
          end else if (in_byte_i == 8'h5C) begin
            emit   = 1'b0;
            mode_d = MODE_ESC;
          end else begin
            job_o = jsu_pkg::byte_job(in_byte_i);
          end
        end
        MODE_ESC: begin
          mode_d = MODE_BODY;
          emit   = 1'b1;
          case (in_byte_i)
            8'h22, 8'h5C, 8'h2F: job_o = jsu_pkg::byte_job(in_byte_i);
            8'h62:               job_o = jsu_pkg::byte_job(8'h08);
            8'h66:               job_o = jsu_pkg::byte_job(8'h0C);
            8'h6E:               job_o = jsu_pkg::byte_job(8'h0A);
            8'h72:               job_o = jsu_pkg::byte_job(8'h0D);
            8'h74:               job_o = jsu_pkg::byte_job(8'h09);
            8'h75: begin
              emit        = 1'b0;
              mode_d      = MODE_HEX;
              high_d      = '0;
              cnt_d       = '0;
              bad_digit_d = 1'b0;
            end
            default: begin
              job_o  = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_BAD_ESC);
              mode_d = MODE_DRAIN;
            end
          endcase
        end
        MODE_HEX: begin
          high_d      = high_new;
          cnt_d       = cnt_q + 3'd1;
          bad_digit_d = bad_any;
          if (cnt_q == 3'd3) begin
            if (bad_any) begin
              emit   = 1'b1;
              job_o  = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_BAD_U);
              mode_d = MODE_DRAIN;
            end else if (high_new inside {[16'hD800:16'hDBFF]}) begin
              mode_d       = MODE_PAIR;
              low_d        = '0;
              cnt_d        = '0;
              bad_digit_d  = 1'b0;
              bad_prefix_d = 1'b0;
            end else if (high_new inside {[16'hDC00:16'hDFFF]}) begin
              emit   = 1'b1;
              job_o  = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_UNPAIRED);
              mode_d = MODE_DRAIN;
            end else begin
              emit   = 1'b1;
              job_o  = jsu_pkg::utf8_job({5'd0, high_new});
              mode_d = MODE_BODY;
              cnt_d  = '0;
            end
          end
        end
        MODE_PAIR: begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd0) begin
            bad_prefix_d = bad_prefix_q || (in_byte_i != 8'h5C);
          end else if (cnt_q == 3'd1) begin
            bad_prefix_d = bad_prefix_q || (in_byte_i != 8'h75);
          end else begin
            low_d       = low_new;
            bad_digit_d = bad_any;
          end
          if (cnt_q == 3'd5) begin
            emit   = 1'b1;
            mode_d = MODE_DRAIN;
            if (bad_prefix_q) begin
              job_o = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_UNPAIRED);
            end else if (bad_any) begin
              job_o = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_BAD_LOW);
            end else if (!(low_new inside {[16'hDC00:16'hDFFF]})) begin
              job_o = jsu_pkg::status_job(jsu_pkg::ST_ERROR, jsu_pkg::ERR_UNPAIRED);
            end else begin
              job_o  = jsu_pkg::utf8_job(pair_cp);
              mode_d = MODE_BODY;
              cnt_d  = '0;
            end
          end
        end
        default: begin
          mode_d = MODE_DRAIN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      high_q       <= '0;
      low_q        <= '0;
      cnt_q        <= '0;
      bad_digit_q  <= 1'b0;
      bad_prefix_q <= 1'b0;
    end else if (accept) begin
      mode_q       <= mode_d;
      high_q       <= high_d;
      low_q        <= low_d;
      cnt_q        <= cnt_d;
      bad_digit_q  <= bad_digit_d;
      bad_prefix_q <= bad_prefix_d;
    end
  end

endmodule

// File: rtl/jsu_queue.sv
// ---------------------------------------------------------------------------
// jsu_queue: two-entry job queue
// Decouples the parser from the output sequencer; push and pop may happen
// in the same cycle.
// ---------------------------------------------------------------------------
module jsu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output jsu_pkg::job_t head_o
);

  jsu_pkg::job_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// File: rtl/jsu_back.sv
// ---------------------------------------------------------------------------
// jsu_back: output sequencer
// Walks the head job one byte per beat into a registered output stage and
// marks the job's final beat.
// ---------------------------------------------------------------------------
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  jsu_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic [1:0]    status_o,
  output logic [3:0]    error_code_o,
  output logic          last_o
);

  logic       valid_q;
  logic [1:0] idx_q;
  logic [7:0] byte_q;
  logic [1:0] status_q;
  logic [3:0] err_q;
  logic       last_q;
  logic       load;
  logic       take;
  logic       is_last;

  assign load    = !valid_q || out_ready_i;
  assign take    = load && q_valid_i;
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = take && is_last;

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign status_o     = status_q;
  assign error_code_o = err_q;
  assign last_o       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= q_valid_i;
      if (take) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q   <= head_i.bytes[idx_q];
      status_q <= head_i.status;
      err_q    <= head_i.err;
      last_q   <= is_last;
    end
  end

endmodule

// File: rtl/json_string_unescape_utf8.sv
// ---------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string literal unescaper with UTF-8 output
// Decodes a quoted JSON string arriving one byte per beat into UTF-8 bytes,
// a close marker, or a numbered error.
// ---------------------------------------------------------------------------
// The block takes one input beat per clock cycle whenever its two-entry job
// queue has room. The first data byte after reset, after a closing quote or
// after an end-of-input beat is the opening quote and is not checked. Plain
// bytes and short escapes give one result beat; a \uXXXX escape (with a
// following low surrogate joined into one code point) gives one to four
// UTF-8 beats, and the output carries one beat per cycle while m_axis_tready
// is high, so a long UTF-8 sequence can hold the input back once the queue
// has filled. A closing quote gives a status-1 beat, and a bad byte or an
// early end of input gives a status-2 beat with its error code; after an
// error, data beats are dropped until an end-of-input beat. The tlast flag
// marks the final result beat caused by one input beat. Between input and
// output, the parser writes each result's job into the job queue, and the
// output sequencer then moves it into the output register.
// Input and output stall independently; the output register accepts a new
// beat in the same cycle the previous one is taken.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] func: 0 data byte, 1 end of input
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last_of_run
);

  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  jsu_pkg::job_t push_job;
  jsu_pkg::job_t head_job;
  logic [7:0]    out_byte;
  logic [3:0]    error_code;

  // The parser classifies each beat and produces at most one job per beat.
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // The queue lets the parser run ahead while a multi-byte job drains.
  jsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  // The sequencer splits each job into result beats.
  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .status_o     (m_axis_tuser),
    .error_code_o (error_code),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, error_code, out_byte};

endmodule
